/* rtl/srci_pkg.sv */
`timescale 1ns / 1ps
package srci_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_RUN      = 64;

  localparam int STEP_WIDTH  = FRAC_BITS + 4;
  localparam int PHASE_WIDTH = FRAC_BITS + 5;
  localparam int COEF_WIDTH  = SAMPLE_WIDTH + 5;
  localparam int PROD_WIDTH  = COEF_WIDTH + FRAC_BITS + 1;
  localparam int RUN_WIDTH   = $clog2(MAX_RUN);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PHASE_WIDTH-1:0] ONE_PHASE = PHASE_WIDTH'(1) << FRAC_BITS;
  localparam logic [STEP_WIDTH-1:0]  STEP_RESET = STEP_WIDTH'(1) << FRAC_BITS;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_CUBIC  = 1'b1;

  localparam logic REG_PHASE_STEP  = 1'b0;
  localparam logic REG_INTERP_MODE = 1'b1;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0]   c0;
    logic signed [COEF_WIDTH-1:0]   c1;
    logic signed [COEF_WIDTH-1:0]   c2;
    logic signed [SAMPLE_WIDTH-1:0] base;
  } srci_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHECK,
    B_MUL,
    B_ACC
  } srci_state_t;

endpackage

/* rtl/srci_front.sv */
`timescale 1ns / 1ps
module srci_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  logic signed [srci_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                                  mode,
  input  logic                                  q_full,
  output logic                                  full,
  output logic                                  q_push,
  output srci_pkg::srci_entry_t                 q_entry
);
  import srci_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] hist_oldest_r, hist_middle_r, hist_newest_r;
  logic signed [COEF_WIDTH-1:0]   e0, e1, e2, e3, d12;

  assign full   = q_full;
  assign q_push = push & ~q_full;

  always_comb begin
    e0  = COEF_WIDTH'(hist_oldest_r);
    e1  = COEF_WIDTH'(hist_middle_r);
    e2  = COEF_WIDTH'(hist_newest_r);
    e3  = COEF_WIDTH'(in_sample);
    d12 = e1 - e2;
    if (mode == MODE_CUBIC) begin
      q_entry.c0   = (d12 <<< 1) + d12 + e3 - e0;
      q_entry.c1   = (e2 <<< 2) - e3 + (e0 <<< 1) - ((e1 <<< 2) + e1);
      q_entry.c2   = e2 - e0;
      q_entry.base = hist_middle_r;
    end else begin
      q_entry.c0   = e3 - e2;
      q_entry.c1   = '0;
      q_entry.c2   = '0;
      q_entry.base = hist_newest_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_oldest_r <= '0;
      hist_middle_r <= '0;
      hist_newest_r <= '0;
    end else if (q_push) begin
      hist_oldest_r <= hist_middle_r;
      hist_middle_r <= hist_newest_r;
      hist_newest_r <= in_sample;
    end
  end

endmodule

/* rtl/srci_queue.sv */
`timescale 1ns / 1ps
module srci_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  srci_pkg::srci_entry_t wr_entry,
  input  logic                  rd_en,
  output srci_pkg::srci_entry_t rd_entry,
  output logic                  q_full,
  output logic                  q_valid
);
  import srci_pkg::*;

  localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  srci_entry_t              mem_r [QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0]     wptr_r, rptr_r;
  logic [CNT_WIDTH-1:0]     cnt_r;

  assign q_full   = (cnt_r == CNT_WIDTH'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign rd_entry = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= (wptr_r == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (rd_en) begin
        rptr_r <= (rptr_r == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!wr_en && rd_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/srci_back.sv */
`timescale 1ns / 1ps
module srci_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   mode,
  input  logic [srci_pkg::STEP_WIDTH-1:0]        step,
  input  logic                                   q_valid,
  input  srci_pkg::srci_entry_t                  q_entry,
  output logic                                   q_pop,
  input  logic                                   pop,
  output logic                                   empty,
  output logic signed [srci_pkg::SAMPLE_WIDTH-1:0] out_sample,
  output logic                                   out_run_last
);
  import srci_pkg::*;

  localparam logic [1:0] HORNER_LAST = 2'd2;
  localparam logic signed [COEF_WIDTH-1:0] SAT_MAX =
    COEF_WIDTH'((2 ** (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [COEF_WIDTH-1:0] SAT_MIN = -SAT_MAX - 1;

  srci_state_t                    state_r, state_nxt;
  logic signed [COEF_WIDTH-1:0]   c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt;
  logic signed [SAMPLE_WIDTH-1:0] base_r, base_nxt;
  logic signed [COEF_WIDTH-1:0]   mop_r, mop_nxt;
  logic signed [PROD_WIDTH-1:0]   prod_r, prod_nxt;
  logic [1:0]                     k_r, k_nxt;
  logic [RUN_WIDTH-1:0]           n_r, n_nxt;
  logic [PHASE_WIDTH-1:0]         phase_r, phase_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic                           run_last_r, run_last_nxt;

  logic signed [PROD_WIDTH-1:0]   ma, mb, rnd_add, rounded;
  logic signed [COEF_WIDTH-1:0]   y_sum, acc_next;
  logic [PHASE_WIDTH-1:0]         psum;
  logic                           last, slot_free;

  assign empty        = ~out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_run_last = run_last_r;

  always_comb begin
    ma        = PROD_WIDTH'(mop_r);
    mb        = PROD_WIDTH'($signed({1'b0, phase_r[FRAC_BITS-1:0]}));
    psum      = phase_r + PHASE_WIDTH'(step);
    last      = (psum >= ONE_PHASE) || (n_r == RUN_WIDTH'(MAX_RUN - 1));
    slot_free = ~out_valid_r | pop;
    acc_next  = COEF_WIDTH'(prod_r >>> FRAC_BITS) + ((k_r == 2'd0) ? c1_r : c2_r);
    if (mode == MODE_CUBIC) begin
      rnd_add = PROD_WIDTH'(1) <<< FRAC_BITS;
      rounded = (prod_r + rnd_add) >>> (FRAC_BITS + 1);
    end else begin
      rnd_add = PROD_WIDTH'(1) <<< (FRAC_BITS - 1);
      rounded = (prod_r + rnd_add) >>> FRAC_BITS;
    end
    y_sum = COEF_WIDTH'(base_r) + COEF_WIDTH'(rounded);

    state_nxt      = state_r;
    c0_nxt         = c0_r;
    c1_nxt         = c1_r;
    c2_nxt         = c2_r;
    base_nxt       = base_r;
    mop_nxt        = mop_r;
    prod_nxt       = prod_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    phase_nxt      = phase_r;
    out_valid_nxt  = out_valid_r & ~pop;
    out_sample_nxt = out_sample_r;
    run_last_nxt   = run_last_r;
    q_pop          = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          c0_nxt    = q_entry.c0;
          c1_nxt    = q_entry.c1;
          c2_nxt    = q_entry.c2;
          base_nxt  = q_entry.base;
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        n_nxt = '0;
        if (phase_r >= ONE_PHASE) begin
          phase_nxt = phase_r - ONE_PHASE;
          state_nxt = B_IDLE;
        end else begin
          mop_nxt   = c0_r;
          k_nxt     = '0;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        prod_nxt  = ma * mb;
        state_nxt = B_ACC;
      end
      B_ACC: begin
        if (mode == MODE_CUBIC && k_r != HORNER_LAST) begin
          mop_nxt   = acc_next;
          k_nxt     = k_r + 1'b1;
          state_nxt = B_MUL;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (y_sum > SAT_MAX) begin
            out_sample_nxt = SAMPLE_WIDTH'(SAT_MAX);
          end else if (y_sum < SAT_MIN) begin
            out_sample_nxt = SAMPLE_WIDTH'(SAT_MIN);
          end else begin
            out_sample_nxt = SAMPLE_WIDTH'(y_sum);
          end
          run_last_nxt = last;
          n_nxt        = n_r + 1'b1;
          if (last) begin
            phase_nxt = (psum >= ONE_PHASE) ? psum - ONE_PHASE : '0;
            state_nxt = B_IDLE;
          end else begin
            phase_nxt = psum;
            mop_nxt   = c0_r;
            k_nxt     = '0;
            state_nxt = B_MUL;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      k_r         <= '0;
      n_r         <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c0_r         <= c0_nxt;
    c1_r         <= c1_nxt;
    c2_r         <= c2_nxt;
    base_r       <= base_nxt;
    mop_r        <= mop_nxt;
    prod_r       <= prod_nxt;
    out_sample_r <= out_sample_nxt;
    run_last_r   <= run_last_nxt;
  end

endmodule

/* rtl/sample_rate_converter_interp.sv */
`timescale 1ns / 1ps
// Streaming resampler with linear or Catmull-Rom cubic interpolation.
// Input samples are written through push/full; a sample transfers at a clock
// edge where push is high and full is low. Results are read through
// empty/pop; the oldest result sits on out_sample and out_run_last while
// empty is low and transfers at an edge where pop is high.
// Each input causes zero or more results, at most 64; out_run_last marks the
// last result of an input. The APB port sets phase_step at address 0 and
// interp_mode at address 4; write them only while the block is idle.
// Inputs go through a two-entry queue to the interpolation engine, whose
// single multiplier sets the pace: per input the engine loads an entry and
// checks the phase, then per result it alternates multiply and accumulate
// steps, repeating them over the Horner terms in cubic mode. When the engine
// is free, empty falls when the first result of the input is registered.
// When the receiver stalls, one finished result is held and the engine
// waits; inputs keep transferring until the queue fills.
// Reset clears the sample history and phase and restores a step of one and
// cubic mode.
module sample_rate_converter_interp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     push,
  output logic                                     full,
  input  logic signed [srci_pkg::SAMPLE_WIDTH-1:0] in_sample,
  output logic                                     empty,
  input  logic                                     pop,
  output logic signed [srci_pkg::SAMPLE_WIDTH-1:0] out_sample,
  output logic                                     out_run_last,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [2:0]                               paddr,
  input  logic [31:0]                              pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import srci_pkg::*;

  logic [STEP_WIDTH-1:0] step_r;
  logic                  mode_r;
  logic                  q_full, q_push, q_valid, q_pop;
  srci_entry_t           push_entry, pop_entry;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_INTERP_MODE) ? 32'(mode_r) : 32'(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      mode_r <= MODE_CUBIC;
    end else if (wr_en) begin
      if (paddr[2] == REG_PHASE_STEP) begin
        step_r <= pwdata[STEP_WIDTH-1:0];
      end else begin
        mode_r <= pwdata[0];
      end
    end
  end

  srci_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_sample (in_sample),
    .mode      (mode_r),
    .q_full    (q_full),
    .full      (full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  srci_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_entry (push_entry),
    .rd_en    (q_pop),
    .rd_entry (pop_entry),
    .q_full   (q_full),
    .q_valid  (q_valid)
  );

  srci_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .mode         (mode_r),
    .step         (step_r),
    .q_valid      (q_valid),
    .q_entry      (pop_entry),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_sample   (out_sample),
    .out_run_last (out_run_last)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import srci_pkg::*;

  localparam longint UNITY = longint'(1) << FRAC_BITS;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } resampled_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           push = 1'b0;
  logic                           full;
  logic signed [SAMPLE_WIDTH-1:0] in_sample = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic                           out_run_last;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [2:0]                     paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  // Shadow of the resampler state and registers.
  logic signed [SAMPLE_WIDTH-1:0] hist_old = '0;
  logic signed [SAMPLE_WIDTH-1:0] hist_mid = '0;
  logic signed [SAMPLE_WIDTH-1:0] hist_new = '0;
  logic [PHASE_WIDTH-1:0]         phase = '0;
  logic [STEP_WIDTH-1:0]          step_reg = STEP_RESET;
  logic                           mode_reg = MODE_CUBIC;

  resampled_t expected_out[$];
  int sender_idle = 0;
  int recv_stall = 0;
  int error_count = 0;
  int cycle_count = 0;
  int samples_sent = 0;
  int results_checked = 0;

  sample_rate_converter_interp dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_sample(in_sample),
    .empty(empty),
    .pop(pop),
    .out_sample(out_sample),
    .out_run_last(out_run_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_sample(input longint v);
    longint hi;
    hi = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic void predict_resample(input logic signed [SAMPLE_WIDTH-1:0] x);
    longint y0, y1, y2, y3, ph, ca, cb, cc, acc, y;
    int n;
    resampled_t r;
    y0 = hist_old;
    y1 = hist_mid;
    y2 = hist_new;
    y3 = x;
    ph = phase;
    n = 0;
    while (ph < UNITY && n < MAX_RUN) begin
      if (mode_reg == MODE_CUBIC) begin
        ca = 3 * (y1 - y2) + y3 - y0;
        cb = 4 * y2 - y3 + 2 * y0 - 5 * y1;
        cc = y2 - y0;
        acc = ((ca * ph) >>> FRAC_BITS) + cb;
        acc = ((acc * ph) >>> FRAC_BITS) + cc;
        y = y1 + ((acc * ph + UNITY) >>> (FRAC_BITS + 1));
      end else begin
        y = y2 + (((y3 - y2) * ph + (UNITY >> 1)) >>> FRAC_BITS);
      end
      y = clamp_sample(y);
      ph += longint'(step_reg);
      n++;
      r.sample = y[SAMPLE_WIDTH-1:0];
      r.last = !(ph < UNITY && n < MAX_RUN);
      expected_out.push_back(r);
    end
    if (ph < UNITY) ph = 0;
    else ph -= UNITY;
    phase = ph[PHASE_WIDTH-1:0];
    hist_old = hist_mid;
    hist_mid = hist_new;
    hist_new = x;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_out.size());
      $display("FAIL sample_rate_converter_interp");
      $finish;
    end
  end

  // Result side: check each transfer against the oldest prediction.
  always @(posedge clk) begin
    resampled_t want;
    if (rst_n && pop && !empty) begin
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("unexpected result sample=%0d last=%0b",
                                  out_sample, out_run_last));
      end else begin
        want = expected_out.pop_front();
        results_checked++;
        if (out_sample !== want.sample)
          report_mismatch($sformatf("out_sample got %0d expected %0d",
                                    out_sample, want.sample));
        if (out_run_last !== want.last)
          report_mismatch($sformatf("out_run_last got %0b expected %0b",
                                    out_run_last, want.last));
      end
    end
    pop <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] x);
    while ($urandom_range(99) < sender_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (full);
    predict_resample(x);
    samples_sent++;
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PHASE_STEP) step_reg = value[STEP_WIDTH-1:0];
    else mode_reg = value[0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_extremes();
    // Two samples at the reset settings, then cubic at a fractional step.
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    wait_drained();
    write_register(REG_PHASE_STEP, 32'd21845);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd32767);
  endtask

  task automatic test_linear_mode();
    wait_drained();
    write_register(REG_INTERP_MODE, {31'd0, MODE_LINEAR});
    write_register(REG_PHASE_STEP, 32'd32768);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
  endtask

  task automatic test_run_cap();
    wait_drained();
    // Upper bits must be dropped by the register width.
    write_register(REG_PHASE_STEP, 32'hFFF0_0000);
    write_register(REG_INTERP_MODE, 32'hFFFF_FFFF);
    send_sample(16'sd12345);
    send_sample(-16'sd32768);
    wait_drained();
    write_register(REG_PHASE_STEP, 32'h1230_0400);
    write_register(REG_INTERP_MODE, 32'hFFFF_FFFE);
    send_sample(16'sd32767);
    send_sample(-16'sd20000);
  endtask

  task automatic test_downsample();
    wait_drained();
    write_register(REG_PHASE_STEP, 32'd1048575);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd5);
  endtask

  task automatic test_random_traffic();
    int sender_pct[4];
    int stall_pct[4];
    logic [STEP_WIDTH-1:0] step;
    logic signed [SAMPLE_WIDTH-1:0] s;
    int kind;
    sender_pct = '{0, 85, 0, 28};
    stall_pct = '{0, 0, 85, 28};
    s = '0;
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      kind = $urandom_range(9);
      if (kind == 0) step = 20'd1024;
      else if (kind == 1) step = 20'd1048575;
      else if (kind < 4) step = 20'($urandom_range(1048575, 1024));
      else step = 20'($urandom_range(131072, 8192));
      write_register(REG_PHASE_STEP, {12'($urandom), step});
      write_register(REG_INTERP_MODE, {31'($urandom), 1'($urandom)});
      sender_idle = sender_pct[p % 4];
      recv_stall = stall_pct[p % 4];
      for (int i = 0; i < 25; i++) begin
        if (p == 2 && i == 13) begin
          while (expected_out.size() != 0) begin
            push <= 1'b0;
            @(posedge clk);
          end
        end
        kind = $urandom_range(9);
        if (kind < 6) s = 16'($urandom);
        else if (kind < 8) s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else s = s + 16'($urandom_range(1023)) - 16'sd512;
        send_sample(s);
      end
    end
    sender_idle = 0;
    recv_stall = 0;
  endtask

  initial begin
    int directed_count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_linear_mode();
    test_run_cap();
    test_downsample();
    directed_count = samples_sent;
    test_random_traffic();
    wait_drained();
    $display("Checked %0d results from %0d input samples (%0d directed).",
             results_checked, samples_sent, directed_count);
    $display("Linear and cubic modes, steps from zero to the maximum, with idle phases.");
    if (error_count == 0) begin
      $display("PASS sample_rate_converter_interp");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("FAIL sample_rate_converter_interp");
    end
    $finish;
  end

endmodule
